// ----- sv/pwbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwbd_pkg
// Shared types and constants for the pulse width bit decoder.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned BIT_CNT_W = 3;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 24'd500000;

    localparam logic STATUS_BYTE    = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef struct packed
    {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              status;
    } result_t;

endpackage

// ----- sv/pwbd_decode.sv -----
// ----------------------------------------------------------------------------
// pwbd_decode
// Edge timing and bit decision state; one line sample per step, at most one
// result (byte complete or timeout) per step.
// ----------------------------------------------------------------------------
module pwbd_decode #(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                level,
    input  logic [pwbd_pkg::CFG_W-1:0]          timeout_ticks,
    output pwbd_pkg::result_t                   result
);
    import pwbd_pkg::*;

    localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    phase_t                  phase_reg, phase_next;
    logic                    prev_reg, prev_next;
    logic [BIT_CNT_W-1:0]    bits_reg, bits_next;
    logic [TIMER_WIDTH-1:0]  high_reg, high_next;
    logic [TIMER_WIDTH-1:0]  edge_reg, edge_next;
    logic [TIMER_WIDTH-1:0]  since_reg, since_next;
    logic [BYTE_W-1:0]       shift_reg, shift_next;

    logic                    rise;
    logic                    fall;
    logic                    bit_val;
    logic [BYTE_W-1:0]       shifted;
    logic [TIMER_WIDTH-1:0]  edge_inc;
    logic [TIMER_WIDTH-1:0]  since_inc;
    logic                    expired;
    logic                    byte_done;

    assign rise      = level & ~prev_reg;
    assign fall      = ~level & prev_reg;
    assign bit_val   = ~(edge_reg > high_reg);
    assign shifted   = {bit_val, shift_reg[BYTE_W-1:1]};
    assign edge_inc  = (edge_reg == TIMER_MAX) ? edge_reg : edge_reg + TIMER_ONE;
    assign since_inc = (since_reg == TIMER_MAX) ? since_reg : since_reg + TIMER_ONE;
    assign expired   = CMP_W'(since_inc) > CMP_W'(timeout_ticks);
    assign byte_done = (bits_reg == {BIT_CNT_W{1'b1}});

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rise)
                        phase_next = PH_HIGH;
                end
                PH_HIGH, PH_LOW:
                begin
                    if (rise)
                        phase_next = PH_HIGH;
                    else if (expired)
                        phase_next = PH_IDLE;
                    else if (phase_reg == PH_HIGH && fall)
                        phase_next = PH_LOW;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // counters, shift register and result
    always_comb
    begin
        prev_next  = prev_reg;
        bits_next  = bits_reg;
        high_next  = high_reg;
        edge_next  = edge_reg;
        since_next = since_reg;
        shift_next = shift_reg;
        result     = '{valid: 1'b0, data_byte: '0, status: STATUS_BYTE};
        if (step)
        begin
            prev_next = level;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rise)
                    begin
                        edge_next  = TIMER_ONE;
                        since_next = '0;
                    end
                end
                PH_HIGH, PH_LOW:
                begin
                    if (rise)
                    begin
                        edge_next  = TIMER_ONE;
                        since_next = '0;
                        if (byte_done)
                        begin
                            result     = '{valid: 1'b1, data_byte: shifted,
                                           status: STATUS_BYTE};
                            bits_next  = '0;
                            shift_next = '0;
                        end
                        else
                        begin
                            bits_next  = bits_reg + BIT_CNT_W'(1);
                            shift_next = shifted;
                        end
                    end
                    else if (expired)
                    begin
                        result     = '{valid: 1'b1, data_byte: '0,
                                       status: STATUS_TIMEOUT};
                        bits_next  = '0;
                        high_next  = '0;
                        edge_next  = '0;
                        since_next = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        since_next = since_inc;
                        if (phase_reg == PH_HIGH && fall)
                        begin
                            high_next = edge_reg;
                            edge_next = TIMER_ONE;
                        end
                        else
                            edge_next = edge_inc;
                    end
                end
                default:
                begin
                    bits_next  = '0;
                    shift_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            prev_reg  <= 1'b0;
            bits_reg  <= '0;
            high_reg  <= '0;
            edge_reg  <= '0;
            since_reg <= '0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            bits_reg  <= bits_next;
            high_reg  <= high_next;
            edge_reg  <= edge_next;
            since_reg <= since_next;
            shift_reg <= shift_next;
        end
    end

`ifndef SYNTH
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> (bits_reg == '0 && since_reg == '0 && shift_reg == '0))
        else $error("idle with live reception state");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_TIMEOUT) |=> phase_reg == PH_IDLE)
        else $error("timeout did not return to idle");
`endif

endmodule

// ----- sv/pwbd_out_buf.sv -----
// ----------------------------------------------------------------------------
// pwbd_out_buf
// Output register for decoded results on the master stream side.
// ----------------------------------------------------------------------------
module pwbd_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwbd_pkg::result_t             result,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pwbd_pkg::BYTE_W-1:0]   m_tdata,
    output logic [0:0]                    m_tuser
);
    import pwbd_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              status_reg;

    assign advance = ~valid_reg | m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            byte_reg   <= result.data_byte;
            status_reg <= result.status;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = byte_reg;
    assign m_tuser[0] = status_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(result.valid && valid_reg && !m_tready))
        else $error("result overwrote an untaken transfer");
`endif

endmodule

// ----- sv/pulse_width_bit_decoder.sv -----
// path: input register, then decode, then the output register that drives m_tvalid
// throughput: one sample per cycle unless the output stalls; input register and decode step together
// output register stalls the input side only while a result waits and m_tready is low
// reset: rst_n asynchronous, clears decoder to idle and timeout_ticks to 500000
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder
// Decodes pulse width coded bits from a sampled line into bytes, with timeout.
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder #(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] rx_level, [7:1] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pwbd_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] data_byte
    output logic [0:0]                    m_tuser,   // [0] status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pwbd_pkg::CFG_W-1:0]    cfg_data   // [23:0] timeout_ticks
);
    import pwbd_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic             in_level_reg;
    logic [CFG_W-1:0] timeout_reg;
    logic             advance;
    logic             step;
    result_t          result;

    assign step      = in_valid_reg & advance;
    assign s_tready  = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid)
                timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_level_reg <= s_tdata[0];
    end

    pwbd_decode #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .level         (in_level_reg),
        .timeout_ticks (timeout_reg),
        .result        (result)
    );

    pwbd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");
`endif

endmodule

// ----- bench/tb_pulse_width_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_pulse_width_bit_decoder
// Drives sampled line levels into the pulse width bit decoder and checks each
// decoded byte or timeout against a cycle-free model of the decoder held here.
// A short table of hand-built line waveforms comes first, then random bit
// trains, long low stretches and line noise under several timeout settings,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_pulse_width_bit_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import pwbd_pkg::*;

    localparam int          TW         = 24;
    localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};
    localparam int          STALL_LIMIT = 2000;
    localparam int          SEG_SAMPLES = 120;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       status;
    } rx_result_t;

    typedef enum logic [1:0]
    {
        ROW_RUN,
        ROW_BITS,
        ROW_CFG
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t    kind;
        logic         lvl;
        logic [7:0]   n;
        logic [7:0]   val;
        logic [3:0]   long_t;
        logic [3:0]   short_t;
        logic [23:0]  cfg;
        logic         chk;
        logic [7:0]   exp_byte;
        logic         exp_status;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'd0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // decoder model state
    logic              line_prev = 1'b0;
    phase_t            rx_phase = PH_IDLE;
    logic [3:0]        bit_cnt = '0;
    logic [TW-1:0]     high_len = '0;
    logic [TW-1:0]     level_len = '0;
    logic [TW-1:0]     rise_len = '0;
    logic [7:0]        shreg = '0;
    logic [CFG_W-1:0]  tmo = TIMEOUT_RESET;

    rx_result_t        decoded_q[$];
    int                mismatches = 0;
    int                sent_cnt = 0;
    int                stall_cycles = 0;
    int                snd_idle = 10;
    int                rcv_idle = 46;
    bit                typed_on = 1'b0;
    rx_result_t        typed_res;
    stim_row_t         dir_rows [0:23];

    pulse_width_bit_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [0] rx_level, [7:1] zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] data_byte
        .m_tuser  (m_tuser),    // [0] status
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)    // [23:0] timeout_ticks
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    // advances the model by one line sample, returns 1 when a result is due
    function automatic bit decode_sample(input logic lvl, output rx_result_t res);
        logic rise;
        logic fall;
        rise = lvl && !line_prev;
        fall = !lvl && line_prev;
        line_prev = lvl;
        res.data_byte = 8'd0;
        res.status = STATUS_BYTE;
        if (rx_phase == PH_IDLE)
        begin
            if (rise)
            begin
                rx_phase = PH_HIGH;
                level_len = TW'(1);
                rise_len = '0;
            end
            return 1'b0;
        end
        if (rise)
        begin
            // low longer than high gives 0, ties give 1
            shreg = {(level_len <= high_len), shreg[7:1]};
            bit_cnt = bit_cnt + 1'b1;
            rx_phase = PH_HIGH;
            level_len = TW'(1);
            rise_len = '0;
            if (bit_cnt == 4'd8)
            begin
                res.data_byte = shreg;
                bit_cnt = '0;
                shreg = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (rx_phase == PH_HIGH && fall)
        begin
            high_len = level_len;
            level_len = TW'(1);
            rx_phase = PH_LOW;
        end
        else
        begin
            level_len = sat_inc(level_len);
        end
        rise_len = sat_inc(rise_len);
        if (rise_len > TW'(tmo))
        begin
            res.status = STATUS_TIMEOUT;
            rx_phase = PH_IDLE;
            bit_cnt = '0;
            high_len = '0;
            level_len = '0;
            rise_len = '0;
            shreg = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic put_sample(input logic lvl);
        rx_result_t res;
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, lvl};
        do
            @(posedge clk);
        while (!s_tready);
        sent_cnt++;
        if (decode_sample(lvl, res))
        begin
            if (typed_on)
                res = typed_res;
            decoded_q.push_back(res);
        end
    endtask

    task automatic send_bit(input int hi, input int lo);
        repeat (hi) put_sample(1'b1);
        repeat (lo) put_sample(1'b0);
    endtask

    // only written once the decoder has drained
    task automatic write_timeout(input logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tmo = v;
    endtask

    function automatic int rand_dur();
        return ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    endfunction

    task automatic random_burst();
        int pick;
        int lim;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            repeat (8) send_bit(rand_dur(), rand_dur());
        end
        else if (pick < 85)
        begin
            lim = (tmo < 60) ? int'(tmo) + 3 : 60;
            repeat ($urandom_range(1, lim)) put_sample(1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 12)) put_sample(1'($urandom_range(1)));
        end
    endtask

    // receive side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result data_byte %02h status %0d",
                             $time, m_tdata, m_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    if (m_tdata !== decoded_q[0].data_byte)
                    begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, decoded_q[0].data_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== decoded_q[0].status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, decoded_q[0].status, m_tuser[0]);
                        mismatches++;
                    end
                    void'(decoded_q.pop_front());
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int seg;
        int seg_start;
        logic [CFG_W-1:0] seg_tmo [0:5];
        int hi;
        int lo;

        dir_rows = '{
            // line high on the first sample after reset counts as a rise
            '{ROW_RUN,  1'b1, 8'd3,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b0, 8'd2,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_BITS, 1'b0, 8'd0,  8'h96, 4'd2, 4'd1, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b0, 8'd4,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_CFG,  1'b0, 8'd0,  8'h00, 4'd0, 4'd0, 24'd1,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b0, 8'd3,  8'h00, 4'd0, 4'd0, 24'd0,    1'b1, 8'h00, STATUS_TIMEOUT},
            // all ties decode as ones
            '{ROW_BITS, 1'b0, 8'd0,  8'h00, 4'd1, 4'd1, 24'd0,    1'b1, 8'hFF, STATUS_BYTE},
            '{ROW_RUN,  1'b1, 8'd2,  8'h00, 4'd0, 4'd0, 24'd0,    1'b1, 8'h00, STATUS_TIMEOUT},
            '{ROW_RUN,  1'b0, 8'd2,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            // zero timeout fires on the first sample after the rise
            '{ROW_CFG,  1'b0, 8'd0,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b1, 8'd2,  8'h00, 4'd0, 4'd0, 24'd0,    1'b1, 8'h00, STATUS_TIMEOUT},
            '{ROW_RUN,  1'b0, 8'd1,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_CFG,  1'b0, 8'd0,  8'h00, 4'd0, 4'd0, 24'hFFFFFF, 1'b0, 8'h00, STATUS_BYTE},
            '{ROW_BITS, 1'b0, 8'd0,  8'hA5, 4'd3, 4'd2, 24'd0,    1'b1, 8'hA5, STATUS_BYTE},
            '{ROW_BITS, 1'b0, 8'd0,  8'h3C, 4'd4, 4'd1, 24'd0,    1'b1, 8'h3C, STATUS_BYTE},
            '{ROW_BITS, 1'b0, 8'd0,  8'hFF, 4'd2, 4'd2, 24'd0,    1'b1, 8'hFF, STATUS_BYTE},
            '{ROW_BITS, 1'b0, 8'd0,  8'h00, 4'd3, 4'd1, 24'd0,    1'b1, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b0, 8'd40, 8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b1, 8'd1,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_CFG,  1'b0, 8'd0,  8'h00, 4'd0, 4'd0, 24'd5,    1'b0, 8'h00, STATUS_BYTE},
            '{ROW_RUN,  1'b1, 8'd6,  8'h00, 4'd0, 4'd0, 24'd0,    1'b1, 8'h00, STATUS_TIMEOUT},
            '{ROW_RUN,  1'b0, 8'd1,  8'h00, 4'd0, 4'd0, 24'd0,    1'b0, 8'h00, STATUS_BYTE},
            // period one sample longer than the timeout still decodes
            '{ROW_BITS, 1'b0, 8'd0,  8'h0F, 4'd3, 4'd3, 24'd0,    1'b1, 8'hFF, STATUS_BYTE},
            '{ROW_RUN,  1'b0, 8'd7,  8'h00, 4'd0, 4'd0, 24'd0,    1'b1, 8'h00, STATUS_TIMEOUT}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 10;
        rcv_idle = 46;
        foreach (dir_rows[i])
        begin
            typed_on = dir_rows[i].chk;
            typed_res.data_byte = dir_rows[i].exp_byte;
            typed_res.status = dir_rows[i].exp_status;
            case (dir_rows[i].kind)
                ROW_CFG:
                    write_timeout(dir_rows[i].cfg);
                ROW_RUN:
                    repeat (dir_rows[i].n) put_sample(dir_rows[i].lvl);
                default:
                begin
                    for (int b = 0; b < 8; b++)
                    begin
                        hi = dir_rows[i].val[b] ? dir_rows[i].long_t : dir_rows[i].short_t;
                        lo = dir_rows[i].val[b] ? dir_rows[i].short_t : dir_rows[i].long_t;
                        send_bit(hi, lo);
                    end
                    // closing rise, also the first rise of the next byte
                    put_sample(1'b1);
                end
            endcase
        end
        typed_on = 1'b0;

        seg_tmo[0] = 24'hFFFFFF;
        seg_tmo[1] = 24'd9;
        seg_tmo[2] = 24'd4;
        seg_tmo[3] = 24'($urandom_range(13, 60));
        seg_tmo[4] = 24'd1;
        seg_tmo[5] = 24'($urandom_range(24'h000100, 24'hFFFFFE));
        for (seg = 0; seg < 6; seg++)
        begin
            snd_idle = (seg < 2) ? 10 : (seg < 4) ? 46 : 0;
            rcv_idle = (seg < 2) ? 46 : (seg < 4) ? 10 : 0;
            write_timeout(seg_tmo[seg]);
            seg_start = sent_cnt;
            while (sent_cnt - seg_start < SEG_SAMPLES)
                random_burst();
        end

        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
